>>> sv/occbs_pkg.sv
// Package for the occupancy block size search: configuration, micro-op and control types,
// register indexes, reset values and the microcode program. Used by the divider, sequencer, datapath and top level.
`default_nettype none

package occbs_pkg;

    localparam int DIV_DW  = 19;   // dividend and quotient width of the divider
    localparam int DIV_VW  = 31;   // divisor width (non-negative 32-bit request)
    localparam int PC_W    = 3;

    localparam int CFG_W   = 19;
    localparam int IDX_W   = 3;

    typedef logic [IDX_W-1:0] t_idx;
    localparam t_idx REG_BLK_THREAD_CAP     = 3'd0;
    localparam t_idx REG_BLK_SHARED_CAP     = 3'd1;
    localparam t_idx REG_MAX_THREADS_PER_SM = 3'd2;
    localparam t_idx REG_MAX_SHARED_PER_SM  = 3'd3;
    localparam t_idx REG_MAX_BLOCKS_PER_SM  = 3'd4;

    typedef struct packed {
        logic [10:0] blk_thread_cap;
        logic [18:0] blk_shared_cap;
        logic [12:0] max_threads_per_sm;
        logic [18:0] max_shared_bytes_per_sm;
        logic [5:0]  max_blocks_per_sm;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        blk_thread_cap:          11'd1024,
        blk_shared_cap:          19'd49152,
        max_threads_per_sm:      13'd2048,
        max_shared_bytes_per_sm: 19'd65536,
        max_blocks_per_sm:       6'd32
    };

    typedef enum logic [2:0] {
        OP_WAIT_IN,
        OP_DIV_START,
        OP_DIV_WAIT,
        OP_BRANCH,
        OP_EVAL,
        OP_EMIT
    } t_op;

    typedef enum logic {
        SEL_SB_NEED,
        SEL_SS_NEED
    } t_sel;

    typedef enum logic [1:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_NEED_ZERO,
        CND_IN_RANGE
    } t_cond;

    typedef logic [PC_W-1:0] t_pc;

    typedef struct packed {
        t_op   op;
        t_sel  sel;
        t_cond cond;
        t_pc   target;
    } t_ctrl;

    typedef struct packed {
        logic stall;
        logic need_zero;
        logic in_range;
    } t_stat;

    localparam t_pc P_IDLE  = 3'd0;
    localparam t_pc P_CHK   = 3'd1;
    localparam t_pc P_UB    = 3'd2;
    localparam t_pc P_UB_W  = 3'd3;
    localparam t_pc P_Q1    = 3'd4;
    localparam t_pc P_Q1_W  = 3'd5;
    localparam t_pc P_LOOP  = 3'd6;
    localparam t_pc P_EMIT  = 3'd7;

    function automatic t_ctrl f_ucode(input t_pc pc);
        t_ctrl w;
        w = '{op: OP_WAIT_IN, sel: SEL_SB_NEED, cond: CND_NEVER, target: P_IDLE};
        case (pc)
            P_IDLE:  w = '{op: OP_WAIT_IN,   sel: SEL_SB_NEED, cond: CND_NEVER,
                           target: P_IDLE};
            P_CHK:   w = '{op: OP_BRANCH,    sel: SEL_SB_NEED, cond: CND_NEED_ZERO,
                           target: P_LOOP};
            P_UB:    w = '{op: OP_DIV_START, sel: SEL_SB_NEED, cond: CND_NEVER,
                           target: P_IDLE};
            P_UB_W:  w = '{op: OP_DIV_WAIT,  sel: SEL_SB_NEED, cond: CND_NEVER,
                           target: P_IDLE};
            P_Q1:    w = '{op: OP_DIV_START, sel: SEL_SS_NEED, cond: CND_NEVER,
                           target: P_IDLE};
            P_Q1_W:  w = '{op: OP_DIV_WAIT,  sel: SEL_SS_NEED, cond: CND_NEVER,
                           target: P_IDLE};
            P_LOOP:  w = '{op: OP_EVAL,      sel: SEL_SB_NEED, cond: CND_IN_RANGE,
                           target: P_LOOP};
            P_EMIT:  w = '{op: OP_EMIT,      sel: SEL_SB_NEED, cond: CND_ALWAYS,
                           target: P_IDLE};
            default: w = '{op: OP_WAIT_IN,   sel: SEL_SB_NEED, cond: CND_ALWAYS,
                           target: P_IDLE};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> sv/occbs_div.sv
// Restoring serial divider, one quotient bit per cycle.
// Depends on occbs_pkg for the operand widths.
`default_nettype none

module occbs_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [occbs_pkg::DIV_DW-1:0]  i_dividend,
    input  wire logic [occbs_pkg::DIV_VW-1:0]  i_divisor,
    output logic                               o_done,
    output logic [occbs_pkg::DIV_DW-1:0]       o_quotient
);

    localparam int CW = $clog2(occbs_pkg::DIV_DW + 1);

    logic [occbs_pkg::DIV_VW:0]   r_rem;
    logic [occbs_pkg::DIV_DW-1:0] r_quo;
    logic [occbs_pkg::DIV_VW-1:0] r_dvs;
    logic [CW-1:0]                r_cnt;
    logic                         r_busy;
    logic                         r_done;

    logic [occbs_pkg::DIV_VW:0]   trial;
    logic                         fits;

    assign trial = {r_rem[occbs_pkg::DIV_VW-1:0], r_quo[occbs_pkg::DIV_DW-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(occbs_pkg::DIV_DW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[occbs_pkg::DIV_DW-2:0], fits};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

>>> sv/occbs_seq.sv
// Microcode sequencer: step counter, program table lookup and conditional jumps.
// Depends on occbs_pkg for the control word, status and program.
`default_nettype none

module occbs_seq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire occbs_pkg::t_stat  i_stat,
    output occbs_pkg::t_ctrl       o_ctrl
);

    occbs_pkg::t_pc   r_pc;
    occbs_pkg::t_pc   n_pc;
    occbs_pkg::t_ctrl ctrl;
    logic             taken;

    assign ctrl = occbs_pkg::f_ucode(r_pc);

    always_comb begin
        case (ctrl.cond)
            occbs_pkg::CND_NEVER:     taken = 1'b0;
            occbs_pkg::CND_ALWAYS:    taken = 1'b1;
            occbs_pkg::CND_NEED_ZERO: taken = i_stat.need_zero;
            occbs_pkg::CND_IN_RANGE:  taken = i_stat.in_range;
            default:                  taken = 1'b0;
        endcase
        if (i_stat.stall) begin
            n_pc = r_pc;
        end else if (taken) begin
            n_pc = ctrl.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= occbs_pkg::P_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl = ctrl;

endmodule

`default_nettype wire

>>> sv/occbs_dp.sv
// Datapath driven by the microcode: request capture, divider operands, candidate loop
// and the output register. Depends on occbs_pkg and instantiates occbs_div.
`default_nettype none

module occbs_dp #(
    parameter int WARP_THREADS = 32,
    parameter int THREAD_LIMIT = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire occbs_pkg::t_cfg   i_cfg,
    input  wire occbs_pkg::t_ctrl  i_ctrl,
    output occbs_pkg::t_stat       o_stat,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire logic [31:0]       i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output logic [10:0]            o_out_size,
    output logic                   o_out_status
);

    localparam int UW   = $clog2(THREAD_LIMIT + 1);
    localparam int SZW  = $clog2(THREAD_LIMIT) + 2;
    localparam int KMAX = $clog2(THREAD_LIMIT);
    localparam int KW   = $clog2(KMAX + 1);
    localparam int OW   = 6 + KMAX;
    localparam int DW   = occbs_pkg::DIV_DW;
    localparam int VW   = occbs_pkg::DIV_VW;
    localparam int RL   = $clog2(WARP_THREADS);
    localparam int RS   = DW + RL;
    localparam int RMW  = DW + 1;
    localparam logic [RMW-1:0] RECIP =
        RMW'(((64'd1 << RS) + 64'(WARP_THREADS) - 64'd1) / 64'(WARP_THREADS));

    // Exact quotient by the warp size for any dividend of DW bits.
    function automatic logic [DW-1:0] f_div_warp(input logic [DW-1:0] x);
        logic [DW+RMW-1:0] p;
        p = (DW+RMW)'(x) * (DW+RMW)'(RECIP);
        return DW'(p >> RS);
    endfunction

    logic [VW-1:0]  r_need;
    logic [UW-1:0]  r_upper;
    logic [12:0]    r_wsm;
    logic [DW-1:0]  r_bsh;
    logic [SZW-1:0] r_size;
    logic [KW-1:0]  r_k;
    logic [UW-1:0]  r_best_size;
    logic [OW-1:0]  r_best_occ;
    logic           r_out_valid;
    logic [10:0]    r_out_size;
    logic           r_out_status;

    logic           in_fire;
    logic           out_free;
    logic           div_start;
    logic           div_done;
    logic [DW-1:0]  div_q;
    logic [DW-1:0]  div_a;
    logic [VW-1:0]  div_b;
    logic [DW-1:0]  upper0;
    logic [DW-1:0]  wsm0;
    logic [DW-1:0]  bsh0;
    logic           in_range;
    logic [DW-1:0]  lim_a;
    logic [5:0]     blocks;
    logic [OW-1:0]  occ;
    logic [UW+10:0] size_ext;

    assign in_fire   = (i_ctrl.op == occbs_pkg::OP_WAIT_IN) && i_in_valid;
    assign out_free  = !r_out_valid || i_out_ready;
    assign div_start = (i_ctrl.op == occbs_pkg::OP_DIV_START);

    always_comb begin
        case (i_ctrl.sel)
            occbs_pkg::SEL_SB_NEED: begin
                div_a = i_cfg.blk_shared_cap;
                div_b = r_need;
            end
            occbs_pkg::SEL_SS_NEED: begin
                div_a = i_cfg.max_shared_bytes_per_sm;
                div_b = r_need;
            end
            default: begin
                div_a = '0;
                div_b = '0;
            end
        endcase
    end

    occbs_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_a),
        .i_divisor  (div_b),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    assign upper0 = (DW'(i_cfg.blk_thread_cap) < DW'(THREAD_LIMIT))
                    ? DW'(i_cfg.blk_thread_cap) : DW'(THREAD_LIMIT);
    assign wsm0   = f_div_warp(DW'(i_cfg.max_threads_per_sm));
    assign bsh0   = f_div_warp(div_q);

    assign in_range = (r_size <= SZW'(r_upper));
    assign lim_a    = (DW'(r_wsm) < r_bsh) ? DW'(r_wsm) : r_bsh;
    assign blocks   = (lim_a < DW'(i_cfg.max_blocks_per_sm))
                      ? lim_a[5:0] : i_cfg.max_blocks_per_sm;
    assign occ      = OW'(blocks) << r_k;

    always_comb begin
        o_stat.stall     = ((i_ctrl.op == occbs_pkg::OP_WAIT_IN)  && !i_in_valid) ||
                           ((i_ctrl.op == occbs_pkg::OP_DIV_WAIT) && !div_done)   ||
                           ((i_ctrl.op == occbs_pkg::OP_EMIT)     && !out_free);
        o_stat.need_zero = (r_need == '0);
        o_stat.in_range  = in_range;
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_need      <= i_in_data[31] ? '0 : i_in_data[VW-1:0];
            r_upper     <= upper0[UW-1:0];
            r_wsm       <= wsm0[12:0];
            r_bsh       <= '1;
            r_size      <= SZW'(WARP_THREADS);
            r_k         <= '0;
            r_best_size <= '0;
            r_best_occ  <= '0;
        end
        if ((i_ctrl.op == occbs_pkg::OP_DIV_WAIT) && div_done) begin
            case (i_ctrl.sel)
                occbs_pkg::SEL_SB_NEED: begin
                    if (div_q < DW'(r_upper)) begin
                        r_upper <= div_q[UW-1:0];
                    end
                end
                occbs_pkg::SEL_SS_NEED: r_bsh <= bsh0;
                default: ;
            endcase
        end
        if ((i_ctrl.op == occbs_pkg::OP_EVAL) && in_range) begin
            if (occ > r_best_occ) begin
                r_best_occ  <= occ;
                r_best_size <= r_size[UW-1:0];
            end
            r_size <= r_size << 1;
            r_k    <= r_k + 1'b1;
            r_wsm  <= r_wsm >> 1;
            r_bsh  <= r_bsh >> 1;
        end
    end

    assign size_ext = {11'd0, r_best_size};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((i_ctrl.op == occbs_pkg::OP_EMIT) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((i_ctrl.op == occbs_pkg::OP_EMIT) && out_free) begin
            r_out_size   <= size_ext[10:0];
            r_out_status <= (r_best_size == '0);
        end
    end

    assign o_in_ready   = (i_ctrl.op == occbs_pkg::OP_WAIT_IN);
    assign o_out_valid  = r_out_valid;
    assign o_out_size   = r_out_size;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

>>> sv/occupancy_block_size_search_top.sv
// Top level of the occupancy block size search: configuration registers, sequencer and
// datapath. Depends on occbs_pkg, occbs_seq and occbs_dp.
//
//  Channel   Direction  Content
//  s_axis    in         tdata[31:0] bytes_per_thread (signed)
//  m_axis    out        tdata[10:0] block_size, [11] status, [15:12] zero
//  cfg       in         i_cfg_index selects the register, i_cfg_wr_data its value
//
// One request occupies the block from its acceptance until its result is emitted. It runs
// through two serial divisions by the requested bytes, one quotient bit a cycle, and then
// the candidate loop, one step per size plus one to leave it. With no shared bytes
// requested both divisions are skipped.
// Reset is synchronous and clears the step counter, the divider control, the result flag
// and the configuration registers. A stalled result holds in the output register while
// the next request is taken; the sequencer waits at its last step until the result is taken.
`default_nettype none

module occupancy_block_size_search_top #(
    parameter int WARP_THREADS = 32,
    parameter int THREAD_LIMIT = 1024
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [31:0]                  s_axis_tdata,   // [31:0] bytes_per_thread
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [15:0]                       m_axis_tdata,   // [10:0] block_size, [11] status
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [occbs_pkg::IDX_W-1:0]  i_cfg_index,
    input  wire logic [occbs_pkg::CFG_W-1:0]  i_cfg_wr_data
);

    occbs_pkg::t_cfg  r_cfg;
    occbs_pkg::t_ctrl ctrl;
    occbs_pkg::t_stat stat;
    logic [10:0]      out_size;
    logic             out_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= occbs_pkg::CFG_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                occbs_pkg::REG_BLK_THREAD_CAP:
                    r_cfg.blk_thread_cap <= i_cfg_wr_data[10:0];
                occbs_pkg::REG_BLK_SHARED_CAP:
                    r_cfg.blk_shared_cap <= i_cfg_wr_data[18:0];
                occbs_pkg::REG_MAX_THREADS_PER_SM:
                    r_cfg.max_threads_per_sm <= i_cfg_wr_data[12:0];
                occbs_pkg::REG_MAX_SHARED_PER_SM:
                    r_cfg.max_shared_bytes_per_sm <= i_cfg_wr_data[18:0];
                occbs_pkg::REG_MAX_BLOCKS_PER_SM:
                    r_cfg.max_blocks_per_sm <= i_cfg_wr_data[5:0];
                default: ;
            endcase
        end
    end

    occbs_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    occbs_dp #(
        .WARP_THREADS (WARP_THREADS),
        .THREAD_LIMIT (THREAD_LIMIT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_ctrl       (ctrl),
        .o_stat       (stat),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .o_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .o_out_size   (out_size),
        .o_out_status (out_status)
    );

    assign m_axis_tdata = {4'd0, out_status, out_size};

endmodule

`default_nettype wire

>>> sv/occbs_checker.sv
// Port-level checks for the occupancy block size search, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module occbs_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction accepted while a request is in work");

    a_error_size_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[11] |-> (m_axis_tdata[10:0] == 11'd0))
        else $error("error status with a nonzero block size");

    a_size_power_of_two: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[10:0]) && (m_axis_tdata[15:12] == 4'd0))
        else $error("block size not a power of two or padding not zero");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind occupancy_block_size_search_top occbs_checker u_occbs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
